FILE: rtl/wpf_pkg.sv
// Shared constants and register codes for the windowed peak finder.
package wpf_pkg;
    localparam int CURVE_LEN_D = 300;
    localparam int WINDOW_D    = 10;
    localparam int END_LIMIT_D = 300;

    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 9;
    localparam int IDX_OUT_W = 9;
    localparam int REG_IDX_W = 1;

    localparam logic [CFG_W-1:0] END_RST = 9'd300;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_START = 1'b0,
        REG_END   = 1'b1
    } t_reg_idx;
endpackage

FILE: rtl/wpf_queue.sv
// Short command queue between the loader and the search engine.
module wpf_queue #(
    parameter int WIDTH = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_vld,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             do_push, do_pop;

    assign o_vld   = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

FILE: rtl/wpf_front.sv
// Sample loader: writes the curve store and queues a search on the last sample.
module wpf_front #(
    parameter int CURVE_LEN = wpf_pkg::CURVE_LEN_D
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [wpf_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                           i_last,
    output logic                           o_wr_en,
    output logic [$clog2(CURVE_LEN)-1:0]   o_wr_addr,
    output logic [wpf_pkg::SAMPLE_W-1:0]   o_wr_data,
    output logic                           o_push,
    output logic [$clog2(CURVE_LEN+1)-1:0] o_push_count
);
    localparam int CW = $clog2(CURVE_LEN+1);
    localparam int AW = $clog2(CURVE_LEN);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          room;

    assign room      = (r_count < CW'(CURVE_LEN));
    assign o_wr_en   = i_accept && room;
    assign o_wr_addr = r_count[AW-1:0];
    assign o_wr_data = i_sample;
    // full store: sample dropped, count stays
    assign n_count      = room ? r_count + CW'(1) : r_count;
    assign o_push       = i_accept && i_last;
    assign o_push_count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= i_last ? '0 : n_count;
        end
    end
endmodule

FILE: rtl/wpf_back.sv
// Search engine: curve store plus the sequencer for window scan and flank check.
module wpf_back #(
    parameter int CURVE_LEN = wpf_pkg::CURVE_LEN_D,
    parameter int WINDOW    = wpf_pkg::WINDOW_D,
    parameter int END_LIMIT = wpf_pkg::END_LIMIT_D
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [$clog2(CURVE_LEN)-1:0]   i_wr_addr,
    input  logic [wpf_pkg::SAMPLE_W-1:0]   i_wr_data,
    input  logic                           i_cmd_vld,
    input  logic [$clog2(CURVE_LEN+1)-1:0] i_cmd_count,
    output logic                           o_cmd_pop,
    input  logic [wpf_pkg::CFG_W-1:0]      i_start_pos,
    input  logic [wpf_pkg::CFG_W-1:0]      i_end_pos,
    output logic                           o_busy,
    output logic                           o_done,
    output logic [wpf_pkg::IDX_OUT_W-1:0]  o_peak_index,
    output logic [wpf_pkg::SAMPLE_W-1:0]   o_peak_value,
    output logic                           o_found
);
    localparam int AW = $clog2(CURVE_LEN);
    localparam int CW = $clog2(CURVE_LEN+1);
    localparam int LW = $clog2(END_LIMIT+1);
    localparam int BW = (CW > wpf_pkg::CFG_W) ? CW : wpf_pkg::CFG_W;
    localparam int PW = ((BW > LW) ? BW : LW) + $clog2(WINDOW+2) + 2;
    localparam int SW = wpf_pkg::SAMPLE_W;

    typedef enum logic [2:0] {
        S_IDLE, S_INIT, S_CHK, S_SCAN, S_LEFT, S_RIGHT, S_DECIDE, S_OUT
    } t_state;

    logic [SW-1:0] r_mem [CURVE_LEN];
    logic [SW-1:0] r_rdata;

    t_state        r_state;
    logic          r_ph;
    logic [PW-1:0] r_cnt, r_e, r_i, r_k, r_px;
    logic [SW-1:0] r_py, r_prev, r_best_val;
    logic [PW-1:0] r_best_idx;
    logic          r_prevv, r_fail, r_pop, r_done;

    logic [PW-1:0] e_a, e_b, scan_px;
    logic          flank_bad;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rdata <= r_mem[r_k[AW-1:0]];
    end

    always_comb begin
        e_a = (PW'(i_end_pos) > PW'(END_LIMIT)) ? PW'(END_LIMIT) : PW'(i_end_pos);
        e_b = (e_a > r_cnt) ? r_cnt : e_a;
        scan_px   = (r_py < r_rdata) ? r_k : r_px;
        flank_bad = r_prevv && (r_prev < r_rdata);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pop   <= 1'b0;
            r_done  <= 1'b0;
            r_ph    <= 1'b0;
        end else begin
            r_pop  <= (r_state == S_IDLE) && i_cmd_vld;
            r_done <= (r_state == S_OUT);
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_vld) begin
                        r_cnt      <= PW'(i_cmd_count);
                        r_best_val <= '0;
                        r_best_idx <= '0;
                        r_state    <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_e     <= e_b;
                    r_i     <= PW'(i_start_pos);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_i + PW'(WINDOW) < r_e) begin
                        r_k     <= r_i;
                        r_px    <= r_i;
                        r_py    <= '0;
                        r_ph    <= 1'b0;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_SCAN: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_px <= scan_px;
                        if (r_py < r_rdata) begin
                            r_py <= r_rdata;
                        end
                        if (r_k == r_i + PW'(WINDOW - 1)) begin
                            r_k     <= scan_px;
                            r_prevv <= 1'b0;
                            r_fail  <= 1'b0;
                            r_state <= S_LEFT;
                        end else begin
                            r_k <= r_k + PW'(1);
                        end
                    end
                end
                S_LEFT: begin
                    // walk down from the peak; fail if the curve rises away from it
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        if (flank_bad) begin
                            r_fail <= 1'b1;
                        end
                        r_prev <= r_rdata;
                        if (r_k == '0 || r_k + PW'(WINDOW) == r_px) begin
                            r_k     <= r_px;
                            r_prevv <= 1'b0;
                            r_state <= S_RIGHT;
                        end else begin
                            r_prevv <= 1'b1;
                            r_k     <= r_k - PW'(1);
                        end
                    end
                end
                S_RIGHT: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        if (flank_bad) begin
                            r_fail <= 1'b1;
                        end
                        r_prev  <= r_rdata;
                        r_prevv <= 1'b1;
                        if (r_k == r_px + PW'(WINDOW) || r_k + PW'(1) == r_cnt) begin
                            r_state <= S_DECIDE;
                        end else begin
                            r_k <= r_k + PW'(1);
                        end
                    end
                end
                S_DECIDE: begin
                    if (!r_fail) begin
                        if (r_py > r_best_val) begin
                            r_best_val <= r_py;
                            r_best_idx <= r_px;
                        end
                        r_i <= r_px + PW'(WINDOW + 1);
                    end else begin
                        r_i <= r_i + PW'(1);
                    end
                    r_state <= S_CHK;
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cmd_pop    = r_pop;
    // busy also covers the cycle the result is shown
    assign o_busy       = (r_state != S_IDLE) || r_done;
    assign o_done       = r_done;
    assign o_peak_index = wpf_pkg::IDX_OUT_W'(r_best_idx);
    assign o_peak_value = r_best_val;
    assign o_found      = (r_best_val != '0);
endmodule

FILE: rtl/windowed_peak_finder_core.sv
// Top level of the windowed peak finder: config registers, loader, queue and search.
//
// Samples are taken one per clock while o_busy is low; each is written to the curve
// store at the next load position (samples past CURVE_LEN are dropped). A transfer with
// i_last set closes the curve and queues a search; o_busy then stays high until the
// search has finished and its result has been shown. The result appears on o_peak_index,
// o_peak_value and o_found for exactly one cycle with o_done high; it cannot be held off,
// so the receiver must take it then. The search is run by one sequencer over a single
// registered read port of the store; each scanned position takes a window scan and then
// a flank check on both sides of the window's peak, plus set-up and hand-over. The store
// needs no clearing pass after reset. start_position and end_position are to be written
// through i_cfg_* only while the block is idle; the block itself does not enforce this.
module windowed_peak_finder_core #(
    parameter int CURVE_LEN = wpf_pkg::CURVE_LEN_D,
    parameter int WINDOW    = wpf_pkg::WINDOW_D,
    parameter int END_LIMIT = wpf_pkg::END_LIMIT_D
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [wpf_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic                            i_last,
    input  logic                            i_cfg_we,
    input  logic [wpf_pkg::REG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wpf_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                            o_done,
    output logic [wpf_pkg::IDX_OUT_W-1:0]   o_peak_index,
    output logic [wpf_pkg::SAMPLE_W-1:0]    o_peak_value,
    output logic                            o_found
);
    localparam int AW = $clog2(CURVE_LEN);
    localparam int CW = $clog2(CURVE_LEN+1);

    logic [wpf_pkg::CFG_W-1:0]    r_start_pos, r_end_pos;
    logic                         accept;
    logic                         wr_en, push, q_vld, q_full, pop, back_busy;
    logic [AW-1:0]                wr_addr;
    logic [wpf_pkg::SAMPLE_W-1:0] wr_data;
    logic [CW-1:0]                push_count, q_count;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pos <= '0;
            r_end_pos   <= wpf_pkg::END_RST;
        end else if (i_cfg_we) begin
            case (wpf_pkg::t_reg_idx'(i_cfg_idx))
                wpf_pkg::REG_START: r_start_pos <= i_cfg_data;
                wpf_pkg::REG_END:   r_end_pos   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a queued or running search owns the store, so loading waits for it
    assign o_busy = q_vld || q_full || back_busy;
    assign accept = i_start && !o_busy;

    wpf_front #(.CURVE_LEN(CURVE_LEN)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_sample     (i_sample),
        .i_last       (i_last),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_push       (push),
        .o_push_count (push_count)
    );

    wpf_queue #(.WIDTH(CW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_count),
        .i_pop   (pop),
        .o_vld   (q_vld),
        .o_full  (q_full),
        .o_data  (q_count)
    );

    wpf_back #(
        .CURVE_LEN (CURVE_LEN),
        .WINDOW    (WINDOW),
        .END_LIMIT (END_LIMIT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_wr_addr    (wr_addr),
        .i_wr_data    (wr_data),
        .i_cmd_vld    (q_vld),
        .i_cmd_count  (q_count),
        .o_cmd_pop    (pop),
        .i_start_pos  (r_start_pos),
        .i_end_pos    (r_end_pos),
        .o_busy       (back_busy),
        .o_done       (o_done),
        .o_peak_index (o_peak_index),
        .o_peak_value (o_peak_value),
        .o_found      (o_found)
    );

    // closing transfer must lock out loading on the next cycle
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last) |=> o_busy)
        else $error("busy not raised after last sample");

    // result strobe is a single-cycle pulse
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held");

    // found flag agrees with reported value
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_found == (o_peak_value != '0)))
        else $error("found flag inconsistent");

    // no sample is taken in the cycle a result is shown
    a_no_load_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !accept)
        else $error("sample taken during result");
endmodule

FILE: dv/tb_windowed_peak_finder_core.sv
// Self-checking testbench for the windowed peak finder core.
`timescale 1ns / 100ps

module tb_windowed_peak_finder_core;
    localparam int SAMPLE_W  = wpf_pkg::SAMPLE_W;
    localparam int CFG_W     = wpf_pkg::CFG_W;
    localparam int IDX_OUT_W = wpf_pkg::IDX_OUT_W;

    localparam int NSTORE  = 300;
    localparam int WIN     = 10;
    localparam int ENDCAP  = 300;
    localparam int N_ITEMS = 1900;

    // One expected search result.
    typedef struct packed {
        logic [IDX_OUT_W-1:0] idx;
        logic [SAMPLE_W-1:0]  val;
        logic                 found;
    } t_peak;

    // Curve model plus the queue of peaks still owed by the block.
    class peak_scoreboard;
        logic [SAMPLE_W-1:0] curve[NSTORE];
        int unsigned         n_loaded;
        int unsigned         start_pos;
        int unsigned         end_pos;
        t_peak               pending[$];
        int unsigned         n_errors;

        function new();
            n_loaded  = 0;
            start_pos = 0;
            end_pos   = 300;
            n_errors  = 0;
        endfunction

        function void write_reg(wpf_pkg::t_reg_idx r, logic [CFG_W-1:0] v);
            if (r == wpf_pkg::REG_START) start_pos = v;
            else                         end_pos   = v;
        endfunction

        // True if the curve does not fall towards x within WIN steps.
        function bit flanks_hold(int unsigned x);
            for (int unsigned d = 0; d < WIN; d++) begin
                if (x >= d + 1 && x - d < n_loaded && curve[x-d] < curve[x-d-1])
                    return 0;
                if (x + d + 1 < n_loaded && curve[x+d] < curve[x+d+1])
                    return 0;
            end
            return 1;
        endfunction

        function t_peak search_peak();
            int unsigned lim, i, px, py;
            t_peak       p;
            lim = end_pos;
            if (lim > ENDCAP)   lim = ENDCAP;
            if (lim > n_loaded) lim = n_loaded;
            p = '0;
            i = start_pos;
            while (i + WIN < lim) begin
                px = i;
                py = 0;
                for (int unsigned j = i; j < i + WIN; j++)
                    if (py < curve[j]) begin
                        py = curve[j];
                        px = j;
                    end
                if (flanks_hold(px)) begin
                    if (py > p.val) begin
                        p.val = SAMPLE_W'(py);
                        p.idx = IDX_OUT_W'(px);
                    end
                    i = px + WIN + 1;
                end else begin
                    i = i + 1;
                end
            end
            p.found = (p.val != 0);
            return p;
        endfunction

        // Called for every accepted sample transfer.
        function void note_sample(logic [SAMPLE_W-1:0] s, logic lst);
            if (n_loaded < NSTORE) begin
                curve[n_loaded] = s;
                n_loaded++;
            end
            if (lst) begin
                pending.push_back(search_peak());
                n_loaded = 0;
            end
        endfunction

        function void check_peak(t_peak got);
            t_peak want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result idx=%0d val=%0d found=%0b",
                         $realtime, got.idx, got.val, got.found);
                n_errors++;
                return;
            end
            want = pending.pop_front();
            if (got.idx !== want.idx) begin
                $display("%0t: peak_index exp %0d got %0d", $realtime, want.idx, got.idx);
                n_errors++;
            end
            if (got.val !== want.val) begin
                $display("%0t: peak_value exp %0d got %0d", $realtime, want.val, got.val);
                n_errors++;
            end
            if (got.found !== want.found) begin
                $display("%0t: found exp %0b got %0b", $realtime, want.found, got.found);
                n_errors++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [SAMPLE_W-1:0]  sample = '0;
    logic                 last = 1'b0;
    logic                 cfg_we = 1'b0;
    wpf_pkg::t_reg_idx    cfg_idx = wpf_pkg::REG_START;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 busy, done, found;
    logic [IDX_OUT_W-1:0] peak_index;
    logic [SAMPLE_W-1:0]  peak_value;

    peak_scoreboard sb = new();
    int unsigned    idle_pct = 0;
    int unsigned    n_sent = 0;

    windowed_peak_finder_core u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_sample     (sample),
        .i_last       (last),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_done       (done),
        .o_peak_index (peak_index),
        .o_peak_value (peak_value),
        .o_found      (found)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Results cannot be stalled: take every strobe as it comes.
    always @(posedge clk) begin
        if (rst_n && done)
            sb.check_peak('{idx: peak_index, val: peak_value, found: found});
    end

    // Hard stop in case the block hangs.
    initial begin
        #30_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // One sample transfer, with random idle cycles ahead of it.
    // Inputs move on the falling edge; busy is stable there.
    task automatic send_sample(logic [SAMPLE_W-1:0] s, logic lst);
        logic was_busy;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge clk);
        end
        start  = 1'b1;
        sample = s;
        last   = lst;
        forever begin
            was_busy = busy;
            @(posedge clk);
            if (!was_busy) break;
            @(negedge clk);
        end
        sb.note_sample(s, lst);
        n_sent++;
    endtask

    // Wait for the block to drain before touching the registers.
    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending.size() != 0 || busy) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(wpf_pkg::t_reg_idx r, logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = r;
        cfg_data = v;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.write_reg(r, v);
    endtask

    task automatic set_window(logic [CFG_W-1:0] s, logic [CFG_W-1:0] e);
        wait_idle();
        write_reg(wpf_pkg::REG_START, s);
        write_reg(wpf_pkg::REG_END, e);
    endtask

    // Random curve. Shapes: noise, isolated bumps, flat, ramp.
    // Most are bumps so the flank check passes often.
    task automatic send_curve(int unsigned len);
        logic [SAMPLE_W-1:0] v[];
        int unsigned         shape, base, h, slope, p, gap, nb, t;
        v = new[len];
        shape = $urandom_range(99);
        base  = $urandom_range(3) == 0 ? 0 : $urandom_range(200);
        for (int unsigned j = 0; j < len; j++) v[j] = SAMPLE_W'(base);
        if (shape < 15) begin
            for (int unsigned j = 0; j < len; j++) v[j] = SAMPLE_W'($urandom());
        end else if (shape < 80) begin
            nb = $urandom_range(1, 4);
            for (int unsigned k = 0; k < nb; k++) begin
                h     = $urandom_range(9) == 0 ? 65535 : $urandom_range(base, 65535);
                slope = $urandom_range(1, 4000);
                p     = $urandom_range(len - 1);
                for (int unsigned j = 0; j < len; j++) begin
                    gap = j > p ? j - p : p - j;
                    t   = gap * slope;
                    if (h > t && h - t > v[j]) v[j] = SAMPLE_W'(h - t);
                end
            end
        end else if (shape < 90) begin
            base = $urandom();
            for (int unsigned j = 0; j < len; j++) v[j] = SAMPLE_W'(base);
        end else begin
            for (int unsigned j = 0; j < len; j++) v[j] = SAMPLE_W'(j * 211 + base);
        end
        for (int unsigned j = 0; j < len; j++) send_sample(v[j], j == len - 1);
    endtask

    function automatic int unsigned pick_len();
        return $urandom_range(99) < 3 ? $urandom_range(280, 312) : $urandom_range(1, 60);
    endfunction

    task automatic run_curves(int unsigned n);
        int unsigned stop_at;
        stop_at = n_sent + n;
        while (n_sent < stop_at) send_curve(pick_len());
    endtask

    initial begin
        int unsigned per_phase;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed: lone last sample, an isolated extreme peak,
        // and a curve overrun past the store depth.
        send_sample(16'hffff, 1'b1);
        for (int unsigned j = 0; j < 23; j++)
            send_sample(j == 11 ? 16'hffff : 16'h0000, j == 22);
        send_curve(NSTORE + 5);
        set_window(9'd300, 9'd300);     // start equal to end
        send_curve(40);
        set_window(9'd0, 9'd0);         // end of zero
        send_curve(30);
        set_window(9'd0, 9'h1ff);       // end above the cap
        send_curve(NSTORE);

        // Random phases: sender busy, then mostly idle, then flat out.
        per_phase = (N_ITEMS - n_sent) / 12;
        for (int unsigned ph = 0; ph < 12; ph++) begin
            idle_pct = ph < 4 ? 31 : (ph < 8 ? 71 : 0);
            case (ph % 4)
                0: set_window(9'd0, 9'd300);
                1: set_window(CFG_W'($urandom_range(0, 30)), CFG_W'($urandom_range(20, 511)));
                2: set_window(CFG_W'($urandom_range(0, 511)), CFG_W'($urandom_range(0, 511)));
                default: set_window(9'h1ff, 9'h1ff);
            endcase
            run_curves(per_phase);
        end

        wait_idle();
        repeat (50) @(negedge clk);
        if (sb.n_errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/wpf_pkg.sv
rtl/wpf_queue.sv
rtl/wpf_front.sv
rtl/wpf_back.sv
rtl/windowed_peak_finder_core.sv
dv/tb_windowed_peak_finder_core.sv
